// ----- hdl/tfet_pkg.sv -----
package tfet_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned AW       = $clog2(CAPACITY);
  localparam int unsigned CW       = $clog2(CAPACITY + 1);
  localparam int unsigned ENT_W    = 80;
  localparam int unsigned DIV_STEPS = 17;

  localparam logic [CW-1:0] CAP_C    = CW'(CAPACITY);
  localparam logic [31:0]   DAY_MS   = 32'd86400000;
  localparam logic [16:0]   Q16_ONE  = 17'd65536;
  localparam logic [16:0]   FADE_MIN = 17'd656;

  localparam logic [1:0] MODE_ADD   = 2'd0;
  localparam logic [1:0] MODE_TICK  = 2'd1;
  localparam logic [1:0] MODE_STRIP = 2'd2;

  localparam logic REG_MAX_ENTRIES   = 1'b0;
  localparam logic REG_SEARCH_WINDOW = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SRD, ST_SCMP, ST_WRD, ST_WEVAL, ST_WDIV, ST_WEMIT, ST_WEND, ST_ADD, ST_FIN
  } state_e;

  typedef enum logic [1:0] {OP_TICK, OP_STRIP, OP_EVICT} op_e;

  typedef struct packed {
    logic [15:0] key;
    logic [31:0] fade;
    logic [31:0] stop;
  } entry_t;

  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic [16:0] level;
  } div_rsp_t;

endpackage

// ----- hdl/tfet_ram.sv -----
module tfet_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hdl/tfet_div.sv -----
module tfet_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tfet_pkg::div_req_t req_i,
  output tfet_pkg::div_rsp_t rsp_o
);
  import tfet_pkg::*;

  logic [32:0] r_q, r_d;
  logic [31:0] d_q, d_d;
  logic [16:0] q_q, q_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        ge;
  logic [32:0] diff, rem;

  // Restoring division: the numerator never exceeds the divisor, so 17
  // quotient bits cover the whole Q16 range including exactly one.
  assign ge   = r_q >= {1'b0, d_q};
  assign diff = r_q - {1'b0, d_q};
  assign rem  = ge ? diff : r_q;

  always_comb begin
    r_d    = r_q;
    d_d    = d_q;
    q_d    = q_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (req_i.start) begin
      r_d    = {1'b0, req_i.num};
      d_d    = req_i.den;
      q_d    = '0;
      cnt_d  = 5'(DIV_STEPS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      r_d   = {rem[31:0], 1'b0};
      q_d   = {q_q[15:0], ge};
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    d_q <= d_d;
    q_q <= q_d;
  end

  assign rsp_o.busy  = busy_q;
  assign rsp_o.level = q_q;

endmodule

// ----- hdl/timed_fade_entry_table_top.sv -----
// Add: store the entry and deliver its report (ST_ADD, ST_FIN); when the table is at its limit,
// first read and compare each searched entry, then, to evict, walk every stored entry and end the walk.
// Tick: read and judge each entry; a kept one is emitted, a fading one divided first; then finish.
// Strip: read and judge each entry, then finish. One request is worked on at a time, and a waiting
// result holds the walk while the receiver stalls.
// Reset empties the table and sets both limits to 64; entry storage is not cleared.
module timed_fade_entry_table_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [15:0] key_i,
  input  logic [31:0] now_i,
  input  logic [31:0] hold_ms_i,
  input  logic [31:0] fade_ms_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] entry_id_o,
  output logic [16:0] fade_level_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [6:0]  cfg_data_i
);
  import tfet_pkg::*;

  state_e state_q, state_d;
  op_e    op_q, op_d;

  logic [15:0]   key_q, key_d, pend_id_q, pend_id_d, out_id_q, out_id_d;
  logic [31:0]   now_q, now_d, fade_t_q, fade_t_d, stop_t_q, stop_t_d, soon_q, soon_d;
  logic [CW-1:0] idx_q, idx_d, w_q, w_d, count_q, count_d, srch_n_q, srch_n_d;
  logic [AW-1:0] pick_q, pick_d;
  logic          found_q, found_d, pend_valid_q, pend_valid_d;
  logic          out_valid_q, out_valid_d, out_last_q, out_last_d;
  logic [16:0]   level_q, level_d, pend_lvl_q, pend_lvl_d, out_lvl_q, out_lvl_d;
  logic [6:0]    max_q, win_q;
  logic [15:0]   ent_key_q;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata, rd_ent;
  logic [ENT_W-1:0] ram_rdata;
  div_req_t      div_req;
  div_rsp_t      div_rsp;

  logic [CW-1:0] limit, n0, idx_nx;
  logic keep, walk_last, srch_last, less, found_n, emit_ok, can_push, push, accept;
  logic [31:0] soon_n;

  tfet_ram #(.WIDTH(ENT_W), .DEPTH(CAPACITY)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  tfet_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign rd_ent    = entry_t'(ram_rdata);
  assign limit     = (max_q > CAP_C) ? CAP_C : max_q;
  assign n0        = (count_q < win_q) ? count_q : win_q;
  assign idx_nx    = idx_q + CW'(1);
  assign walk_last = idx_nx == count_q;
  assign srch_last = idx_nx == srch_n_q;
  assign less      = rd_ent.stop < soon_q;
  assign found_n   = found_q | less;
  assign soon_n    = less ? rd_ent.stop : soon_q;
  assign emit_ok   = level_q >= FADE_MIN;
  assign can_push  = !out_valid_q || !out_stall_i;
  assign accept    = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    case (op_q)
      OP_TICK:  keep = now_q < rd_ent.stop;
      OP_STRIP: keep = rd_ent.key != key_q;
      default:  keep = idx_q[AW-1:0] != pick_q;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (mode_i == MODE_ADD) begin
            if (hold_ms_i == 32'd0 || max_q == 7'd0) begin
              state_d = ST_IDLE;
            end else if (count_q >= limit && n0 != '0) begin
              state_d = ST_SRD;
            end else begin
              state_d = ST_ADD;
            end
          end else if (mode_i == MODE_TICK || mode_i == MODE_STRIP) begin
            state_d = (count_q == '0) ? ST_WEND : ST_WRD;
          end
        end
      end
      ST_SRD: state_d = ST_SCMP;
      ST_SCMP: begin
        if (!srch_last) begin
          state_d = ST_SRD;
        end else if (found_n && soon_n != 32'd0) begin
          state_d = ST_WRD;
        end else begin
          state_d = ST_ADD;
        end
      end
      ST_WRD: state_d = ST_WEVAL;
      ST_WEVAL: begin
        if (keep && op_q == OP_TICK) begin
          state_d = (now_q >= rd_ent.fade) ? ST_WDIV : ST_WEMIT;
        end else begin
          state_d = walk_last ? ST_WEND : ST_WRD;
        end
      end
      ST_WDIV:  state_d = div_rsp.busy ? ST_WDIV : ST_WEMIT;
      ST_WEMIT: begin
        if (emit_ok && pend_valid_q && !can_push) begin
          state_d = ST_WEMIT;
        end else begin
          state_d = walk_last ? ST_WEND : ST_WRD;
        end
      end
      ST_WEND: state_d = (op_q == OP_EVICT) ? ST_ADD : ST_FIN;
      ST_ADD:  state_d = (count_q >= CAP_C) ? ST_IDLE : ST_FIN;
      ST_FIN:  state_d = (pend_valid_q && !can_push) ? ST_FIN : ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    op_d = op_q; key_d = key_q; now_d = now_q; fade_t_d = fade_t_q; stop_t_d = stop_t_q;
    soon_d = soon_q; idx_d = idx_q; w_d = w_q; count_d = count_q; srch_n_d = srch_n_q;
    pick_d = pick_q; found_d = found_q; level_d = level_q;
    pend_valid_d = pend_valid_q; pend_id_d = pend_id_q; pend_lvl_d = pend_lvl_q;
    out_id_d = out_id_q; out_lvl_d = out_lvl_q; out_last_d = out_last_q;
    out_valid_d = out_valid_q && out_stall_i;
    push = 1'b0;
    ram_we = 1'b0; ram_waddr = w_q[AW-1:0]; ram_wdata = rd_ent;
    div_req.start = 1'b0;
    div_req.num   = rd_ent.stop - now_q;
    div_req.den   = rd_ent.stop - rd_ent.fade;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          key_d    = key_i;
          now_d    = now_i;
          fade_t_d = now_i + hold_ms_i;
          stop_t_d = now_i + hold_ms_i + fade_ms_i;
          idx_d    = '0;
          w_d      = '0;
          soon_d   = DAY_MS;
          found_d  = 1'b0;
          srch_n_d = n0;
          op_d     = (mode_i == MODE_STRIP) ? OP_STRIP : OP_TICK;
        end
      end
      ST_SCMP: begin
        soon_d  = soon_n;
        found_d = found_n;
        if (less) begin
          pick_d = idx_q[AW-1:0];
        end
        idx_d = idx_nx;
        if (srch_last) begin
          idx_d = '0;
          w_d   = '0;
          op_d  = OP_EVICT;
        end
      end
      ST_WEVAL: begin
        pend_id_d = pend_id_q;
        if (keep) begin
          ram_we = 1'b1;
          w_d    = w_q + CW'(1);
        end
        level_d = Q16_ONE;
        if (keep && op_q == OP_TICK) begin
          div_req.start = now_q >= rd_ent.fade;
          key_d = key_q;
        end
        if (!(keep && op_q == OP_TICK)) begin
          idx_d = idx_nx;
        end
        ram_wdata = rd_ent;
      end
      ST_WDIV: begin
        if (!div_rsp.busy) begin
          level_d = div_rsp.level;
        end
      end
      ST_WEMIT: begin
        if (!(emit_ok && pend_valid_q && !can_push)) begin
          if (emit_ok) begin
            if (pend_valid_q) begin
              push = 1'b1;
              out_last_d = 1'b0;
            end
            pend_valid_d = 1'b1;
            pend_id_d    = ent_key_q;
            pend_lvl_d   = level_q;
          end
          idx_d = idx_nx;
        end
      end
      ST_WEND: count_d = w_q;
      ST_ADD: begin
        if (count_q < CAP_C) begin
          ram_we       = 1'b1;
          ram_waddr    = count_q[AW-1:0];
          ram_wdata    = '{key: key_q, fade: fade_t_q, stop: stop_t_q};
          count_d      = count_q + CW'(1);
          pend_valid_d = 1'b1;
          pend_id_d    = key_q;
          pend_lvl_d   = Q16_ONE;
        end
      end
      ST_FIN: begin
        if (pend_valid_q && can_push) begin
          push         = 1'b1;
          out_last_d   = 1'b1;
          pend_valid_d = 1'b0;
        end
      end
      default: ;
    endcase
    if (push) begin
      out_valid_d = 1'b1;
      out_id_d    = pend_id_q;
      out_lvl_d   = pend_lvl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_WEVAL) begin
      ent_key_q <= rd_ent.key;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      max_q        <= 7'(CAPACITY);
      win_q        <= 7'(CAPACITY);
      op_q         <= OP_TICK;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      op_q         <= op_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_MAX_ENTRIES:   max_q <= cfg_data_i;
          REG_SEARCH_WINDOW: win_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d; now_q <= now_d; fade_t_q <= fade_t_d; stop_t_q <= stop_t_d;
    soon_q <= soon_d; idx_q <= idx_d; w_q <= w_d; srch_n_q <= srch_n_d;
    pick_q <= pick_d; found_q <= found_d; level_q <= level_d;
    pend_id_q <= pend_id_d; pend_lvl_q <= pend_lvl_d;
    out_id_q <= out_id_d; out_lvl_q <= out_lvl_d; out_last_q <= out_last_d;
  end

  assign in_stall_o   = state_q != ST_IDLE;
  assign cfg_ready_o  = 1'b1;
  assign out_valid_o  = out_valid_q;
  assign entry_id_o   = out_id_q;
  assign fade_level_o = out_lvl_q;
  assign last_o       = out_last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP_C) else $error("entry count above capacity");
  a_compact_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WEVAL) |-> w_q <= idx_q)
    else $error("compaction write ahead of read");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !(out_valid_q && out_stall_i)) else $error("result overwritten");
  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.busy |-> state_q == ST_WDIV) else $error("divider busy outside walk");

endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;
  import tfet_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned SETTLE_CYCLES  = 1600;
  localparam logic [1:0]  MODE_NONE      = 2'd3;

  typedef struct packed {
    logic [15:0] entry_id;
    logic [16:0] fade_level;
    logic        last;
  } report_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  mode_i;
  logic [15:0] key_i;
  logic [31:0] now_i;
  logic [31:0] hold_ms_i;
  logic [31:0] fade_ms_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [15:0] entry_id_o;
  logic [16:0] fade_level_o;
  logic        last_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_index_i;
  logic [6:0]  cfg_data_i;

  timed_fade_entry_table_top i_dut (.*);

  // Shadow of the table that the block should hold.
  logic [15:0] table_key [CAPACITY];
  logic [31:0] table_fade[CAPACITY];
  logic [31:0] table_stop[CAPACITY];
  int unsigned table_count;
  int unsigned lim_entries;
  int unsigned win_size;

  report_t     pending_reports[$];
  report_t     oldest;
  int unsigned errors;
  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  int unsigned hold_left;
  bit          hold_req;
  int unsigned quiet_cycles;
  logic [31:0] t_base;

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    mode_i = MODE_ADD;
    key_i = '0;
    now_i = '0;
    hold_ms_i = '0;
    fade_ms_i = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_MAX_ENTRIES;
    cfg_data_i = '0;
  end

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic drop_entry(input int unsigned idx);
    for (int unsigned i = idx; i + 1 < table_count; i++) begin
      table_key[i]  = table_key[i+1];
      table_fade[i] = table_fade[i+1];
      table_stop[i] = table_stop[i+1];
    end
    if (table_count > 0) table_count--;
  endtask

  task automatic queue_report(input report_t rep);
    pending_reports = {pending_reports, rep};
  endtask

  // Works out the reports that one accepted request must cause.
  task automatic predict_reports(input logic [1:0] mode, input logic [15:0] key,
                                 input logic [31:0] now, input logic [31:0] hold,
                                 input logic [31:0] fdur);
    int unsigned limit, kept, pick, n;
    logic [31:0] fade_t, stop_t, soonest, st, ft;
    logic [63:0] num, den, level;
    bit found;
    report_t rep;
    n = 0;
    case (mode)
      MODE_ADD: begin
        if (hold != 0 && lim_entries != 0) begin
          limit = (lim_entries < CAPACITY) ? lim_entries : CAPACITY;
          fade_t = now + hold;
          stop_t = fade_t + fdur;
          if (table_count >= limit) begin
            soonest = DAY_MS;
            found = 0;
            pick = 0;
            for (int unsigned i = 0; i < table_count && i < win_size; i++) begin
              if (table_stop[i] < soonest) begin
                soonest = table_stop[i];
                pick = i;
                found = 1;
              end
            end
            if (found && soonest != 0) drop_entry(pick);
          end
          if (table_count < CAPACITY) begin
            table_key[table_count]  = key;
            table_fade[table_count] = fade_t;
            table_stop[table_count] = stop_t;
            table_count++;
            rep.entry_id = key;
            rep.fade_level = Q16_ONE;
            rep.last = 1'b1;
            queue_report(rep);
          end
        end
      end
      MODE_TICK: begin
        kept = 0;
        for (int unsigned i = 0; i < table_count; i++) begin
          st = table_stop[i];
          ft = table_fade[i];
          if (now < st) begin
            if (now >= ft) begin
              num = {32'd0, st - now} << 16;
              den = {32'd0, st - ft};
              level = (den != 0) ? num / den : 64'(Q16_ONE);
              if (level > 64'(Q16_ONE)) level = 64'(Q16_ONE);
            end else begin
              level = 64'(Q16_ONE);
            end
            table_key[kept]  = table_key[i];
            table_fade[kept] = ft;
            table_stop[kept] = st;
            kept++;
            if (level >= 64'(FADE_MIN)) begin
              rep.entry_id = table_key[kept-1];
              rep.fade_level = level[16:0];
              rep.last = 1'b0;
              queue_report(rep);
              n++;
            end
          end
        end
        table_count = kept;
        if (n > 0) pending_reports[pending_reports.size()-1].last = 1'b1;
      end
      MODE_STRIP: begin
        kept = 0;
        for (int unsigned i = 0; i < table_count; i++) begin
          if (table_key[i] != key) begin
            table_key[kept]  = table_key[i];
            table_fade[kept] = table_fade[i];
            table_stop[kept] = table_stop[i];
            kept++;
          end
        end
        table_count = kept;
      end
      default: ;
    endcase
  endtask

  task automatic send_request(input logic [1:0] mode, input logic [15:0] key,
                              input logic [31:0] now, input logic [31:0] hold,
                              input logic [31:0] fdur);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= mode;
    key_i <= key;
    now_i <= now;
    hold_ms_i <= hold;
    fade_ms_i <= fdur;
    do @(posedge clk_i); while (in_stall_o);
    predict_reports(mode, key, now, hold, fdur);
  endtask

  // Lets the block drain completely; requests without reports may still be running.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [6:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    if (idx == REG_MAX_ENTRIES) lim_entries = value;
    else win_size = value;
  endtask

  task automatic set_limits(input logic [6:0] max_e, input logic [6:0] window);
    wait_drained();
    write_reg(REG_MAX_ENTRIES, max_e);
    write_reg(REG_SEARCH_WINDOW, window);
  endtask

  // Mostly a coherent timeline with small keys so that strips and evictions hit;
  // now and then fully random fields so that every bit toggles.
  task automatic send_random_request();
    int unsigned pick;
    logic [15:0] key;
    pick = $urandom_range(0, 99);
    key = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15));
    if (pick < 55) begin
      if ($urandom_range(0, 9) == 0)
        send_request(MODE_ADD, key, $urandom, $urandom, $urandom);
      else
        send_request(MODE_ADD, key, t_base, $urandom_range(1, 400), $urandom_range(0, 1500));
    end else if (pick < 85) begin
      t_base += $urandom_range(0, 300);
      if ($urandom_range(0, 19) == 0)
        send_request(MODE_TICK, key, $urandom, $urandom, $urandom);
      else
        send_request(MODE_TICK, key, t_base, $urandom, $urandom);
    end else if (pick < 95) begin
      send_request(MODE_STRIP, key, $urandom, $urandom, $urandom);
    end else if (pick < 98) begin
      send_request(MODE_NONE, key, $urandom, $urandom, $urandom);
    end else begin
      send_request(MODE_ADD, key, t_base, 32'd0, $urandom);
    end
  endtask

  task automatic test_directed();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    send_request(MODE_ADD, 16'd0, 32'd0, 32'd0, 32'd50);
    send_request(MODE_NONE, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(MODE_ADD, 16'hFFFF, 32'd0, 32'd100, 32'd1000);
    send_request(MODE_ADD, 16'd0, 32'd0, 32'd1, 32'd0);
    // Wraps to a stop time of zero, which the next tick drops at once.
    send_request(MODE_ADD, 16'h1234, 32'hFFFF_FF00, 32'h100, 32'd0);
    send_request(MODE_ADD, 16'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(MODE_TICK, 16'd0, 32'd0, 32'd0, 32'd0);
    send_request(MODE_TICK, 16'd0, 32'd600, 32'd0, 32'd0);
    // The fade of the first entry is now below the reporting floor.
    send_request(MODE_TICK, 16'd0, 32'd1095, 32'd0, 32'd0);
    send_request(MODE_STRIP, 16'd7, 32'd0, 32'd0, 32'd0);
    send_request(MODE_TICK, 16'd0, 32'd1100, 32'd0, 32'd0);
    send_request(MODE_ADD, 16'd3, 32'd2000, 32'd1, 32'd0);
    send_request(MODE_ADD, 16'd3, 32'd2000, 32'd5, 32'd65536);
    send_request(MODE_STRIP, 16'd3, 32'd0, 32'd0, 32'd0);
    send_request(MODE_TICK, 16'd0, 32'hFFFF_FFFF, 32'd0, 32'd0);
  endtask

  task automatic test_eviction_limits();
    set_limits(7'd2, 7'd64);
    t_base = 32'd10000;
    send_request(MODE_ADD, 16'd1, t_base, 32'd10, 32'd10);
    send_request(MODE_ADD, 16'd2, t_base, 32'd5, 32'd5);
    send_request(MODE_ADD, 16'd3, t_base, 32'd5, 32'd5);
    send_request(MODE_ADD, 16'd4, 32'hFFFF_FF00, 32'h100, 32'd0);
    send_request(MODE_ADD, 16'd5, t_base, 32'd1, 32'd1);
    send_request(MODE_TICK, 16'd0, t_base, 32'd0, 32'd0);
    repeat (10) send_random_request();
    set_limits(7'd2, 7'd1);
    repeat (12) send_random_request();
    set_limits(7'd3, 7'd0);
    repeat (12) send_random_request();
    set_limits(7'd0, 7'd5);
    repeat (10) send_random_request();
    set_limits(7'd1, 7'd64);
    repeat (12) send_random_request();
    set_limits(7'd127, 7'd127);
    repeat (12) send_random_request();
  endtask

  // Entries that stop beyond the day limit cannot be evicted, so a full table drops adds.
  task automatic test_full_table();
    set_limits(7'd64, 7'd64);
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    for (int i = 0; i < 66; i++)
      send_request(MODE_ADD, 16'(i), 32'h8000_0000, 32'($urandom_range(1, 1000)), 32'd5);
    send_request(MODE_TICK, 16'd0, 32'h8000_0200, 32'd0, 32'd0);
    send_request(MODE_TICK, 16'd0, 32'hFFFF_FFFF, 32'd0, 32'd0);
  endtask

  task automatic test_random_idling();
    int unsigned tx_pct[4] = '{0, 83, 0, 16};
    int unsigned rx_pct[4] = '{0, 0, 83, 16};
    t_base = 32'd0;
    for (int p = 0; p < 4; p++) begin
      tx_idle_pct = tx_pct[p];
      rx_stall_pct = rx_pct[p];
      repeat (30) send_random_request();
    end
  endtask

  task automatic test_output_hold_off();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_req = 1'b1;
    for (int i = 0; i < 16; i++)
      send_request(MODE_ADD, 16'($urandom_range(0, 15)), t_base, 32'd50, 32'd500);
    send_request(MODE_TICK, 16'd0, t_base + 32'd100, 32'd0, 32'd0);
  endtask

  initial begin
    errors = 0;
    table_count = 0;
    lim_entries = 64;
    win_size = 64;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_req = 1'b0;
    t_base = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_eviction_limits();
    test_full_table();
    test_random_idling();
    test_output_hold_off();
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  // Receiver side: random stalls, plus one long hold-off counted here.
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left = 3000;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected report: entry_id %0h fade_level %0d last %0b",
               entry_id_o, fade_level_o, last_o);
        errors++;
      end else begin
        oldest = pending_reports.pop_front();
        if (entry_id_o !== oldest.entry_id) begin
          $error("entry_id: expected %0h, got %0h", oldest.entry_id, entry_id_o);
          errors++;
        end
        if (fade_level_o !== oldest.fade_level) begin
          $error("fade_level: expected %0d, got %0d", oldest.fade_level, fade_level_o);
          errors++;
        end
        if (last_o !== oldest.last) begin
          $error("last: expected %0b, got %0b", oldest.last, last_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial quiet_cycles = 0;

endmodule
